// ----- rtl/mfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mesh face dedup package
// Shared types and codes for the face matching table.
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int NODE_W = 31;
    localparam int KEY_W  = NODE_W + 1;
    localparam int SIZE_W = 4;
    localparam int PORT_NODES = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [1:0] STATUS_ADDED   = 2'd0;
    localparam logic [1:0] STATUS_MATCHED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_READ    = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [3:0]        num_nodes;
        logic [NODE_W-1:0] node_0;
        logic [NODE_W-1:0] node_1;
        logic [NODE_W-1:0] node_2;
        logic [NODE_W-1:0] node_3;
        logic [NODE_W-1:0] node_4;
        logic [NODE_W-1:0] node_5;
        logic [NODE_W-1:0] node_6;
        logic [NODE_W-1:0] node_7;
        logic [7:0]        read_index;
    } mfd_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] entry_index;
        logic       on_surface;
        logic [8:0] face_count;
    } mfd_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_MISS,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_RESP
    } mfd_state_t;

    typedef struct packed {
        logic load;
        logic sort_step;
        logic sort_odd;
        logic scan_read;
        logic scan_next;
        logic hit;
        logic insert;
        logic drop;
        logic mark_read;
        logic read_take;
    } mfd_cmd_t;

    typedef struct packed {
        logic in_read;
        logic face_match;
        logic scan_last;
        logic table_empty;
        logic table_full;
    } mfd_status_t;

endpackage
`default_nettype wire

// ----- rtl/mfd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mfd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mesh face dedup controller
// Sequences sorting, table scan, insert and mark read for one transaction.
// ----------------------------------------------------------------------------
module mfd_ctrl import mfd_pkg::*; #(
    parameter int MAX_NODES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire mfd_status_t stat,
    output mfd_cmd_t         cmd,
    output mfd_state_t       state
);

    localparam int PW = $clog2(MAX_NODES);

    mfd_state_t    state_reg, state_next;
    logic [PW-1:0] pass_reg, pass_next;
    logic          sort_last;

    assign state     = state_reg;
    assign sort_last = (pass_reg == PW'(MAX_NODES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg  <= '0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            ST_IDLE: begin
                pass_next = '0;
                if (s_valid) begin
                    state_next = stat.in_read ? ST_READ_RD : ST_SORT;
                end
            end
            ST_SORT: begin
                pass_next = pass_reg + PW'(1);
                if (sort_last) begin
                    state_next = stat.table_empty ? ST_MISS : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN_CMP;
            ST_SCAN_CMP: begin
                if (stat.face_match) begin
                    state_next = ST_RESP;
                end else if (stat.scan_last) begin
                    state_next = ST_MISS;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MISS:      state_next = ST_RESP;
            ST_READ_RD:   state_next = ST_READ_WAIT;
            ST_READ_WAIT: state_next = ST_RESP;
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SORT: begin
                cmd.sort_step = 1'b1;
                cmd.sort_odd  = pass_reg[0];
            end
            ST_SCAN_RD: cmd.scan_read = 1'b1;
            ST_SCAN_CMP: begin
                cmd.hit       = stat.face_match;
                cmd.scan_next = !stat.face_match;
            end
            ST_MISS: begin
                cmd.insert = !stat.table_full;
                cmd.drop   = stat.table_full;
            end
            ST_READ_RD:   cmd.mark_read = 1'b1;
            ST_READ_WAIT: cmd.read_take = 1'b1;
            ST_RESP:      m_valid = 1'b1;
            default:      cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/mfd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mesh face dedup datapath
// Sort network registers, face and mark memories, count and result register.
// ----------------------------------------------------------------------------
module mfd_datapath import mfd_pkg::*; #(
    parameter int MAX_FACES = 256,
    parameter int MAX_NODES = 8
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mfd_in_t  s_payload,
    input  wire mfd_cmd_t cmd,
    output mfd_status_t   stat,
    output mfd_out_t      result,
    output logic [$clog2(MAX_FACES+1)-1:0] count
);

    localparam int AW    = $clog2(MAX_FACES);
    localparam int CW    = $clog2(MAX_FACES + 1);
    localparam int ROW_W = MAX_NODES * NODE_W + SIZE_W;

    logic [KEY_W-1:0]  key_reg   [MAX_NODES];
    logic [KEY_W-1:0]  key_next  [MAX_NODES];
    logic [NODE_W-1:0] in_nodes  [PORT_NODES];
    logic [SIZE_W-1:0] n_reg, n_sat;
    logic [7:0]        idx_reg;
    logic [AW-1:0]     scan_reg;
    logic [CW-1:0]     count_reg;
    mfd_out_t          result_reg;
    logic [ROW_W-1:0]  row, row_rdata;
    logic              mark_rdata;
    logic              mark_we, mark_wdata;
    logic [AW-1:0]     mark_waddr, idx_addr, count_addr;
    logic [31:0]       idx_wide, scan_wide, count_wide, count_inc_wide;

    assign in_nodes[0] = s_payload.node_0;
    assign in_nodes[1] = s_payload.node_1;
    assign in_nodes[2] = s_payload.node_2;
    assign in_nodes[3] = s_payload.node_3;
    assign in_nodes[4] = s_payload.node_4;
    assign in_nodes[5] = s_payload.node_5;
    assign in_nodes[6] = s_payload.node_6;
    assign in_nodes[7] = s_payload.node_7;

    assign n_sat = (s_payload.num_nodes > SIZE_W'(MAX_NODES))
                 ? SIZE_W'(MAX_NODES) : s_payload.num_nodes;

    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            key_next[i] = key_reg[i];
        end
        if (cmd.load) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                key_next[i] = (SIZE_W'(i) < n_sat) ? {1'b0, in_nodes[i]}
                                                   : {1'b1, {NODE_W{1'b0}}};
            end
        end else if (cmd.sort_step) begin
            for (int i = 0; i + 1 < MAX_NODES; i++) begin
                if ((i % 2 == 1) == cmd.sort_odd) begin
                    if (key_reg[i] > key_reg[i+1]) begin
                        key_next[i]   = key_reg[i+1];
                        key_next[i+1] = key_reg[i];
                    end
                end
            end
        end
    end

    always_comb begin
        row[ROW_W-1 -: SIZE_W] = n_reg;
        for (int i = 0; i < MAX_NODES; i++) begin
            row[i*NODE_W +: NODE_W] = key_reg[i][KEY_W-1] ? '0 : key_reg[i][NODE_W-1:0];
        end
    end

    assign idx_wide       = 32'(idx_reg);
    assign scan_wide      = 32'(scan_reg);
    assign count_wide     = 32'(count_reg);
    assign count_inc_wide = 32'(count_reg) + 32'd1;
    assign idx_addr       = idx_wide[AW-1:0];
    assign count_addr     = count_wide[AW-1:0];

    assign stat.in_read     = (s_payload.opcode == OP_READ);
    assign stat.face_match  = (row_rdata == row);
    assign stat.scan_last   = (scan_wide + 32'd1 >= count_wide);
    assign stat.table_empty = (count_reg == '0);
    assign stat.table_full  = (count_wide >= 32'(MAX_FACES));

    assign mark_we    = cmd.hit || cmd.insert;
    assign mark_wdata = cmd.insert;
    assign mark_waddr = cmd.insert ? count_addr : scan_reg;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_NODES; i++) begin
            key_reg[i] <= key_next[i];
        end
        if (cmd.load) begin
            n_reg   <= n_sat;
            idx_reg <= s_payload.read_index;
        end
        if (cmd.hit) begin
            result_reg <= '{STATUS_MATCHED, scan_wide[7:0], 1'b0, count_wide[8:0]};
        end else if (cmd.insert) begin
            result_reg <= '{STATUS_ADDED, count_wide[7:0], 1'b1, count_inc_wide[8:0]};
        end else if (cmd.drop) begin
            result_reg <= '{STATUS_FULL, 8'd0, 1'b0, count_wide[8:0]};
        end else if (cmd.read_take) begin
            result_reg <= '{STATUS_READ, idx_reg,
                            (idx_wide < count_wide) ? mark_rdata : 1'b0,
                            count_wide[8:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            scan_reg  <= '0;
        end else begin
            if (cmd.load) begin
                scan_reg <= '0;
            end else if (cmd.scan_next) begin
                scan_reg <= scan_reg + AW'(1);
            end
            if (cmd.insert) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    mfd_ram #(.WIDTH(ROW_W), .DEPTH(MAX_FACES)) u_face_ram (
        .aclk  (aclk),
        .we    (cmd.insert),
        .waddr (count_addr),
        .wdata (row),
        .re    (cmd.scan_read),
        .raddr (scan_reg),
        .rdata (row_rdata)
    );

    mfd_ram #(.WIDTH(1), .DEPTH(MAX_FACES)) u_mark_ram (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (cmd.mark_read),
        .raddr (idx_addr),
        .rdata (mark_rdata)
    );

    assign result = result_reg;
    assign count  = count_reg;

endmodule
`default_nettype wire

// ----- rtl/mesh_face_dedup_table_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mesh face dedup table core
// Sorts a face, scans the stored faces for a match and appends or marks it.
// Insert: sort, read and compare stored faces in turn until one matches, else
// add or drop the face, then the result; a transaction is one at a time. Read:
// the mark memory is read, then the result. The scan over the face memory's
// single read port sets the insert rate. Reset clears count and scan index.
// ----------------------------------------------------------------------------
module mesh_face_dedup_table_core import mfd_pkg::*; #(
    parameter int MAX_FACES = 256,
    parameter int MAX_NODES = 8
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire mfd_in_t s_payload,
    output logic         m_valid,
    input  wire logic    m_ready,
    output mfd_out_t     m_payload
);

    mfd_cmd_t    cmd;
    mfd_status_t stat;
    mfd_state_t  state;
    logic [$clog2(MAX_FACES+1)-1:0] count;

    mfd_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd),
        .state   (state)
    );

    mfd_datapath #(.MAX_FACES(MAX_FACES), .MAX_NODES(MAX_NODES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .result    (m_payload),
        .count     (count)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count) <= 32'(MAX_FACES))
        else $error("face count exceeds table size");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction taken while busy");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |=> (state == ST_RESP) && (count != '0))
        else $error("insert did not advance to the result");

endmodule
`default_nettype wire

// ----- tb/tb_mesh_face_dedup_table_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mesh face dedup table core testbench
// Drives insert and read transactions with random idle cycles on both sides.
// A scoreboard keeps its own table of sorted faces and checks every result.
// ----------------------------------------------------------------------------
module tb_mesh_face_dedup_table_core;
    import mfd_pkg::*;

    localparam int FACES = 256;
    localparam int NODES = 8;
    localparam int IN_W  = $bits(mfd_in_t);
    localparam longint CYCLE_LIMIT = 64'd4000000;

    class face_table_scoreboard;
        logic [NODE_W-1:0] face_ids [FACES][NODES];
        logic [3:0]        face_size [FACES];
        logic              face_mark [FACES];
        int unsigned       face_total;
        mfd_out_t          pending_q [$];
        int unsigned       errors;
        int unsigned       n_added, n_matched, n_full, n_read;

        function void note_input(mfd_in_t t);
            logic [NODE_W-1:0] ids [NODES];
            logic [NODE_W-1:0] v;
            mfd_out_t r;
            int n, j, hit;
            ids[0] = t.node_0; ids[1] = t.node_1; ids[2] = t.node_2; ids[3] = t.node_3;
            ids[4] = t.node_4; ids[5] = t.node_5; ids[6] = t.node_6; ids[7] = t.node_7;
            r = '0;
            if (t.opcode == OP_READ) begin
                r.status = STATUS_READ;
                r.entry_index = t.read_index;
                r.on_surface = (t.read_index < face_total) ? face_mark[t.read_index] : 1'b0;
                r.face_count = face_total[8:0];
                pending_q.push_back(r);
                return;
            end
            n = (t.num_nodes > NODES) ? NODES : t.num_nodes;
            for (int i = 1; i < n; i++) begin
                v = ids[i];
                j = i;
                while (j > 0 && ids[j-1] > v) begin
                    ids[j] = ids[j-1];
                    j--;
                end
                ids[j] = v;
            end
            hit = -1;
            for (int e = 0; e < face_total && hit < 0; e++) begin
                if (face_size[e] == n) begin
                    hit = e;
                    for (int i = 0; i < n; i++)
                        if (face_ids[e][i] != ids[i]) hit = -1;
                end
            end
            if (hit >= 0) begin
                face_mark[hit] = 1'b0;
                r.status = STATUS_MATCHED;
                r.entry_index = hit[7:0];
            end else if (face_total >= FACES) begin
                r.status = STATUS_FULL;
            end else begin
                for (int i = 0; i < NODES; i++)
                    face_ids[face_total][i] = (i < n) ? ids[i] : '0;
                face_size[face_total] = n[3:0];
                face_mark[face_total] = 1'b1;
                r.status = STATUS_ADDED;
                r.entry_index = face_total[7:0];
                r.on_surface = 1'b1;
                face_total++;
            end
            r.face_count = face_total[8:0];
            pending_q.push_back(r);
        endfunction

        function void check_result(mfd_out_t got);
            mfd_out_t want;
            if (pending_q.size() == 0) begin
                $error("Result with no transaction outstanding: %h", got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            case (want.status)
                STATUS_ADDED:   n_added++;
                STATUS_MATCHED: n_matched++;
                STATUS_FULL:    n_full++;
                default:        n_read++;
            endcase
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.entry_index !== want.entry_index) begin
                $error("entry_index expected %0d actual %0d", want.entry_index,
                       got.entry_index);
                errors++;
            end
            if (got.on_surface !== want.on_surface) begin
                $error("on_surface expected %0d actual %0d", want.on_surface,
                       got.on_surface);
                errors++;
            end
            if (got.face_count !== want.face_count) begin
                $error("face_count expected %0d actual %0d", want.face_count,
                       got.face_count);
                errors++;
            end
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    mfd_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    mfd_out_t m_payload;

    face_table_scoreboard sb = new();
    longint cycles = 0;
    bit calm = 1'b0;
    logic [NODE_W-1:0] pool [16];

    always #5 aclk = ~aclk;

    mesh_face_dedup_table_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && s_valid && s_ready) sb.note_input(s_payload);
        if (aresetn && m_valid && m_ready) sb.check_result(m_payload);
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
    end

    task automatic send_item(input mfd_in_t t);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 20) @(negedge aclk);
        s_valid <= 1'b1;
        s_payload <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    function automatic mfd_in_t make_face(int n, logic [NODE_W-1:0] a [NODES]);
        mfd_in_t t;
        t = '0;
        t.opcode = OP_INSERT;
        t.num_nodes = n[3:0];
        t.node_0 = a[0]; t.node_1 = a[1]; t.node_2 = a[2]; t.node_3 = a[3];
        t.node_4 = a[4]; t.node_5 = a[5]; t.node_6 = a[6]; t.node_7 = a[7];
        t.read_index = 8'($urandom);
        return t;
    endfunction

    function automatic mfd_in_t make_read(int idx);
        mfd_in_t t;
        t = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom});
        t.opcode = OP_READ;
        t.read_index = idx[7:0];
        return t;
    endfunction

    function automatic mfd_in_t random_face();
        logic [NODE_W-1:0] a [NODES];
        int n;
        n = $urandom_range(15);
        for (int i = 0; i < NODES; i++)
            a[i] = ($urandom_range(3) == 0) ? NODE_W'($urandom) : pool[$urandom_range(15)];
        return make_face(n, a);
    endfunction

    task automatic reversed_face(input mfd_in_t t);
        mfd_in_t r;
        r = t;
        r.node_0 = t.node_7; r.node_1 = t.node_6; r.node_2 = t.node_5;
        r.node_3 = t.node_4; r.node_4 = t.node_3; r.node_5 = t.node_2;
        r.node_6 = t.node_1; r.node_7 = t.node_0;
        send_item(r);
    endtask

    task automatic wait_drained();
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [NODE_W-1:0] a [NODES];
        mfd_in_t t;
        int sent;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < 16; i++) pool[i] = NODE_W'($urandom);

        // Directed part: extremes, read of an empty table, empty faces,
        // duplicate corners, oversized counts and permuted matches.
        send_item(make_read(0));
        for (int i = 0; i < NODES; i++) a[i] = '1;
        send_item(make_face(8, a));
        for (int i = 0; i < NODES; i++) a[i] = '0;
        send_item(make_face(8, a));
        send_item(make_face(0, a));
        send_item(make_face(0, a));
        for (int i = 0; i < NODES; i++) a[i] = NODE_W'(NODES - i);
        send_item(make_face(4, a));
        t = make_face(15, a);
        send_item(t);
        reversed_face(t);
        a[0] = 31'h2AAAAAAA; a[1] = 31'h55555555; a[2] = 31'h2AAAAAAA;
        send_item(make_face(3, a));
        send_item(make_face(1, a));
        send_item(make_face(9, a));
        send_item(make_read(1));
        send_item(make_read(5));
        send_item(make_read(255));
        sent = 14;

        // Random part: mostly faces from a small id pool with permuted repeats.
        for (int k = 0; k < 950; k++) begin
            if (k == 300) begin
                wait_drained();
                calm = 1'b1;
            end
            if (k == 450) calm = 1'b0;
            case ($urandom_range(9))
                0, 1:    send_item(make_read($urandom_range(255)));
                2:       begin
                    t = random_face();
                    send_item(t);
                    reversed_face(t);
                    k++;
                    sent++;
                end
                default: send_item(random_face());
            endcase
            sent++;
        end
        // Push past a full table and read every entry back.
        while (sb.face_total < FACES + 0) begin
            send_item(random_face());
            sent++;
        end
        for (int i = 0; i < 30; i++) begin
            send_item(random_face());
            sent++;
        end
        for (int i = 0; i < FACES; i++) begin
            send_item(make_read(i));
            sent++;
        end
        wait_drained();
        repeat (100) @(posedge aclk);
        $display("Sent %0d transactions, including a full table and a read of every entry.",
                 sent);
        $display("Covered %0d added, %0d matched, %0d dropped when full, %0d reads.",
                 sb.n_added, sb.n_matched, sb.n_full, sb.n_read);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
